// ===== src/scsi_pkg.sv =====
// Package for the sorted coordinate set: field widths, parameter defaults
// and the command/status structs between controller and datapath.
// No dependencies.
package scsi_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int COORD_BITS_DEF    = 16;
  localparam int COORD_W           = 16;
  localparam int POS_W             = 13;

  typedef struct packed {
    logic load;
    logic search_rd;
    logic search_cmp;
    logic end_search;
    logic shift_step;
    logic write_key;
    logic load_out;
  } scsi_cmd_t;

  typedef struct packed {
    logic search_open;
    logic need_shift;
    logic shift_busy;
    logic out_free;
  } scsi_sts_t;

endpackage

// ===== src/scsi_if.sv =====
// Request and response channel interfaces for the sorted coordinate set.
// Depends on scsi_pkg.
interface scsi_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [scsi_pkg::COORD_W-1:0] coord_x;
  logic [scsi_pkg::COORD_W-1:0] coord_y;
  logic [scsi_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, req_type, coord_x, coord_y, coord_z, output ready);
endinterface

interface scsi_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     was_present;
  logic [scsi_pkg::POS_W-1:0] position;
  logic                     did_insert;
  logic                     table_full;
  logic [scsi_pkg::POS_W-1:0] entry_count;

  modport source (output valid, was_present, position, did_insert, table_full,
                  entry_count, input ready);
  modport sink (input valid, was_present, position, did_insert, table_full,
                entry_count, output ready);
endinterface

// ===== src/scsi_datapath.sv =====
// Datapath of the sorted coordinate set: coordinate memory, search bounds,
// shift pointer, entry count and output register.
// Depends on scsi_pkg.
module scsi_datapath #(
  parameter int TABLE_ENTRIES = scsi_pkg::TABLE_ENTRIES_DEF,
  parameter int COORD_BITS    = scsi_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  scsi_pkg::scsi_cmd_t          cmd,
  output scsi_pkg::scsi_sts_t          sts,
  input  logic                         req_type,
  input  logic [scsi_pkg::COORD_W-1:0] coord_x,
  input  logic [scsi_pkg::COORD_W-1:0] coord_y,
  input  logic [scsi_pkg::COORD_W-1:0] coord_z,
  input  logic                         rsp_ready,
  output logic                         rsp_valid,
  output logic                         rsp_was_present,
  output logic [scsi_pkg::POS_W-1:0]   rsp_position,
  output logic                         rsp_did_insert,
  output logic                         rsp_table_full,
  output logic [scsi_pkg::POS_W-1:0]   rsp_entry_count
);
  import scsi_pkg::*;

  localparam int KEY_W = 3 * COORD_BITS;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  logic [KEY_W-1:0] mem [TABLE_ENTRIES];
  logic [KEY_W-1:0] rdata;
  logic [KEY_W-1:0] key;
  logic             ins;
  logic             present;
  logic             inserted;
  logic             full;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] sp;
  logic [CNT_W-1:0] count;
  logic             wpend;
  logic [IDX_W-1:0] waddr;

  logic [CNT_W-1:0] mid_next;
  logic [CNT_W-1:0] sp_m1;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [KEY_W-1:0] mem_wd;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;
  logic [EXT_W-1:0] lo_ext;
  logic [EXT_W-1:0] count_ext;

  assign mid_next  = lo + ((hi - lo) >> 1);
  assign sp_m1     = sp - CNT_W'(1);
  assign lo_ext    = EXT_W'(lo);
  assign count_ext = EXT_W'(count);

  assign sts.search_open = (lo < hi);
  assign sts.need_shift  = ins && !present && (count != FULL_CNT);
  assign sts.shift_busy  = (sp > lo) || wpend;
  assign sts.out_free    = !rsp_valid || rsp_ready;

  always_comb begin
    mem_we = (cmd.shift_step && wpend) || cmd.write_key;
    mem_wa = cmd.write_key ? lo[IDX_W-1:0] : waddr;
    mem_wd = cmd.write_key ? key : rdata;
    mem_re = cmd.search_rd || (cmd.shift_step && (sp > lo));
    mem_ra = cmd.search_rd ? mid_next[IDX_W-1:0] : sp_m1[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      wpend     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.end_search) begin
        wpend <= 1'b0;
      end else if (cmd.shift_step) begin
        wpend <= (sp > lo);
      end
      if (cmd.write_key) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= {coord_x[COORD_BITS-1:0], coord_y[COORD_BITS-1:0],
                  coord_z[COORD_BITS-1:0]};
      ins     <= req_type;
      lo      <= '0;
      hi      <= count;
      present <= 1'b0;
    end
    if (cmd.search_rd) begin
      mid <= mid_next;
    end
    if (cmd.search_cmp) begin
      if (rdata == key) begin
        present <= 1'b1;
        lo      <= mid;
        hi      <= mid;
      end else if (key < rdata) begin
        hi <= mid;
      end else begin
        lo <= mid + CNT_W'(1);
      end
    end
    if (cmd.end_search) begin
      full     <= ins && !present && (count == FULL_CNT);
      inserted <= 1'b0;
      sp       <= count;
    end
    if (cmd.shift_step && (sp > lo)) begin
      waddr <= sp[IDX_W-1:0];
      sp    <= sp_m1;
    end
    if (cmd.write_key) begin
      inserted <= 1'b1;
    end
    if (cmd.load_out) begin
      rsp_was_present <= present;
      rsp_position    <= lo_ext[POS_W-1:0];
      rsp_did_insert  <= inserted;
      rsp_table_full  <= full;
      rsp_entry_count <= count_ext[POS_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("entry count above table size");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.write_key |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance the entry count");

  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> lo <= sp) else $error("shift pointer below insertion point");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> !(rsp_did_insert && rsp_table_full))
    else $error("insert and full flags both set");

endmodule

// ===== src/scsi_ctrl.sv =====
// Controller of the sorted coordinate set: sequences search probes,
// the entry shift, the key write and the result transfer.
// Depends on scsi_pkg.
module scsi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  scsi_pkg::scsi_sts_t sts,
  output scsi_pkg::scsi_cmd_t cmd
);
  import scsi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_SHIFT,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.search_open) begin
          cmd.search_rd = 1'b1;
          state_next    = ST_CMP;
        end else begin
          cmd.end_search = 1'b1;
          state_next     = sts.need_shift ? ST_SHIFT : ST_DONE;
        end
      end
      ST_CMP: begin
        cmd.search_cmp = 1'b1;
        state_next     = ST_SEARCH;
      end
      ST_SHIFT: begin
        if (sts.shift_busy) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.write_key = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == ST_SEARCH)
    else $error("transfer did not start a search");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("more than one command at once");

  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> $past(state) == ST_DONE || $past(state) == ST_SEARCH
      || $past(state) == ST_SHIFT)
    else $error("result loaded without finishing a request");

endmodule

// ===== src/sorted_coordinate_set_insert.sv =====
// Top level of the sorted coordinate set: controller plus datapath on the
// request and response channels. Depends on scsi_pkg, scsi_if, scsi_ctrl
// and scsi_datapath.
//
// Keeps up to TABLE_ENTRIES coordinates in ascending (x, y, z) order in one
// single-port-write memory; reset empties the table at once. One request is
// worked at a time: it is taken, then each binary-search probe reads the
// memory and then compares, with at most ceil(log2(n+1)) probes for n stored
// entries; the search is closed, then for an insert the later entries move
// up one at a time through the single memory port and the key is written,
// and last the result register is loaded once the response side is free of
// the previous result. The result register frees the request side while a
// result waits.
module sorted_coordinate_set_insert #(
  parameter int TABLE_ENTRIES = scsi_pkg::TABLE_ENTRIES_DEF,
  parameter int COORD_BITS    = scsi_pkg::COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  scsi_req_if.sink   req,
  scsi_rsp_if.source rsp
);
  import scsi_pkg::*;

  scsi_cmd_t cmd;
  scsi_sts_t sts;

  scsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scsi_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COORD_BITS    (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (req.req_type),
    .coord_x         (req.coord_x),
    .coord_y         (req.coord_y),
    .coord_z         (req.coord_z),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_was_present (rsp.was_present),
    .rsp_position    (rsp.position),
    .rsp_did_insert  (rsp.did_insert),
    .rsp_table_full  (rsp.table_full),
    .rsp_entry_count (rsp.entry_count)
  );

endmodule
